@@ hdl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
// Holds the phase encoding, command codes, the front-to-back item word and the result word.
package i2cm_pkg;

	localparam logic [2:0] MODE_START = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_READ  = 3'd2;
	localparam logic [2:0] MODE_ACK   = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_S1    = 5'd1,
		PH_S2    = 5'd2,
		PH_S3    = 5'd3,
		PH_WLOW  = 5'd4,
		PH_WHIGH = 5'd5,
		PH_ALOW  = 5'd6,
		PH_AHIGH = 5'd7,
		PH_AEND  = 5'd8,
		PH_RLOW  = 5'd9,
		PH_RHIGH = 5'd10,
		PH_REND  = 5'd11,
		PH_KLOW  = 5'd12,
		PH_KHIGH = 5'd13,
		PH_KEND  = 5'd14,
		PH_T1    = 5'd15,
		PH_T2    = 5'd16,
		PH_T3    = 5'd17
	} phase_t;

	// One tick after classification by the front.
	typedef struct packed {
		logic       cmd_ok;
		phase_t     first_phase;
		logic [7:0] shift_init;
		logic       ack;
		logic       sda;
	} item_t;

	// One result word as it leaves the block.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_received;
	} res_t;

endpackage

@@ hdl/i2cm_fifo.sv @@
// Small register queue used between the stages of the I2C master byte engine.
// Standalone; no package dependencies.
module i2cm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_nxt, rd_ptr_nxt;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	assign wr_ptr_nxt = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
	assign rd_ptr_nxt = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/i2cm_front.sv @@
// Front of the I2C master byte engine: classifies each incoming tick and queues it.
// Depends on i2cm_pkg and i2cm_fifo.
module i2cm_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic           cmd_valid,
	input  logic [2:0]     mode,
	input  logic [7:0]     write_data,
	input  logic           ack_to_send,
	input  logic           sda_in,
	output i2cm_pkg::item_t item,
	output logic           item_valid,
	input  logic           item_take
);
	import i2cm_pkg::*;

	item_t cls;
	logic  q_empty;

	// A command counts only when its mode is one of the five known codes.
	always_comb begin
		cls.cmd_ok     = cmd_valid && (mode inside {[MODE_START:MODE_STOP]});
		cls.shift_init = (mode == MODE_WRITE) ? write_data : 8'd0;
		cls.ack        = ack_to_send;
		cls.sda        = sda_in;
		case (mode)
			MODE_START: cls.first_phase = PH_S1;
			MODE_WRITE: cls.first_phase = PH_WLOW;
			MODE_READ:  cls.first_phase = PH_RLOW;
			MODE_ACK:   cls.first_phase = PH_KLOW;
			MODE_STOP:  cls.first_phase = PH_T1;
			default:    cls.first_phase = PH_IDLE;
		endcase
	end

	i2cm_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(DEPTH)
	) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (item_take),
		.rdata (item),
		.empty (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

@@ hdl/i2cm_back.sv @@
// Back of the I2C master byte engine: the bus phase sequencer, one tick per cycle
// while a tick is queued and the result queue has room. Depends on i2cm_pkg.
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     half_period,
	input  i2cm_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_take,
	input  logic            out_full,
	output i2cm_pkg::res_t  res,
	output logic            res_push
);
	import i2cm_pkg::*;

	phase_t      phase_q, phase_e, phase_d, tgt;
	logic [15:0] wait_q, wait_e, wait_d, reload;
	logic [3:0]  bitc_q, bitc_e;
	logic [7:0]  shift_q, shift_e, lread_q, lread_e;
	logic        ackh_q, ackh_e, scl_q, scl_e, sda_q, sda_e, lack_q, lack_e;
	logic        enter, busy, done;

	assign item_take = item_valid && !out_full;
	assign res_push  = item_take;

	// A half period of zero behaves as one tick.
	assign reload = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;

	// Next state: either start a command, count down, or step to the next phase.
	always_comb begin
		phase_e = phase_q;
		wait_e  = wait_q;
		bitc_e  = bitc_q;
		shift_e = shift_q;
		ackh_e  = ackh_q;
		scl_e   = scl_q;
		sda_e   = sda_q;
		lread_e = lread_q;
		lack_e  = lack_q;
		enter   = 1'b0;
		tgt     = PH_IDLE;
		if (phase_q == PH_IDLE) begin
			if (item.cmd_ok) begin
				bitc_e  = 4'd0;
				shift_e = item.shift_init;
				ackh_e  = item.ack;
				enter   = 1'b1;
				tgt     = item.first_phase;
			end
		end else if (wait_q != 16'd0) begin
			wait_e = wait_q - 16'd1;
		end else begin
			enter = 1'b1;
			case (phase_q)
				PH_WHIGH: begin
					bitc_e  = bitc_q + 4'd1;
					shift_e = {shift_q[6:0], 1'b0};
					tgt     = bitc_e[3] ? PH_ALOW : PH_WLOW;
				end
				PH_RHIGH: begin
					bitc_e = bitc_q + 4'd1;
					tgt    = bitc_e[3] ? PH_REND : PH_RLOW;
				end
				PH_S1:    tgt = PH_S2;
				PH_S2:    tgt = PH_S3;
				PH_WLOW:  tgt = PH_WHIGH;
				PH_ALOW:  tgt = PH_AHIGH;
				PH_AHIGH: tgt = PH_AEND;
				PH_RLOW:  tgt = PH_RHIGH;
				PH_KLOW:  tgt = PH_KHIGH;
				PH_KHIGH: tgt = PH_KEND;
				PH_T1:    tgt = PH_T2;
				PH_T2:    tgt = PH_T3;
				default:  tgt = PH_IDLE;
			endcase
		end
		if (enter) begin
			phase_e = tgt;
			wait_e  = reload;
			case (tgt)
				PH_S1: begin
					scl_e = 1'b1;
					sda_e = 1'b1;
				end
				PH_S2: sda_e = 1'b0;
				PH_WLOW: begin
					if (bitc_e != 4'd0) begin
						scl_e = 1'b0;
					end
					sda_e = shift_e[7];
				end
				PH_ALOW: begin
					scl_e = 1'b0;
					sda_e = 1'b1;
				end
				PH_AHIGH: begin
					scl_e  = 1'b1;
					lack_e = item.sda;
				end
				PH_RLOW: begin
					if (bitc_e != 4'd0) begin
						scl_e = 1'b0;
					end
					sda_e = 1'b1;
				end
				PH_RHIGH: begin
					scl_e   = 1'b1;
					shift_e = {shift_e[6:0], item.sda};
				end
				PH_REND: begin
					scl_e   = 1'b0;
					lread_e = shift_e;
				end
				PH_KLOW: sda_e = ackh_e;
				PH_T1: begin
					scl_e = 1'b0;
					sda_e = 1'b0;
				end
				PH_T3: sda_e = 1'b1;
				PH_WHIGH, PH_KHIGH, PH_T2: scl_e = 1'b1;
				PH_S3, PH_AEND, PH_KEND:   scl_e = 1'b0;
				default: ;
			endcase
		end
	end

	// Outputs: busy on every tick of a command, done on its last tick.
	always_comb begin
		busy = (phase_e != PH_IDLE);
		done = busy && ((phase_e inside {PH_S3, PH_AEND, PH_REND, PH_KEND}) ||
			(phase_e == PH_T3 && wait_e == 16'd0));
		phase_d = done ? PH_IDLE : phase_e;
		wait_d  = done ? 16'd0 : wait_e;
		res.scl          = scl_e;
		res.sda          = sda_e;
		res.busy         = busy;
		res.done         = done;
		res.read_data    = lread_e;
		res.ack_received = lack_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= 16'd0;
			bitc_q  <= 4'd0;
			shift_q <= 8'd0;
			ackh_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			lread_q <= 8'd0;
			lack_q  <= 1'b1;
		end else if (item_take) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			bitc_q  <= bitc_e;
			shift_q <= shift_e;
			ackh_q  <= ackh_e;
			scl_q   <= scl_e;
			sda_q   <= sda_e;
			lread_q <= lread_e;
			lack_q  <= lack_e;
		end
	end

endmodule

@@ hdl/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: front queue, phase sequencer, result queue.
// Depends on i2cm_pkg, i2cm_front, i2cm_back and i2cm_fifo.
//
//   Channel   Handshake              Words carried
//   input     push / full            cmd_valid, mode, write_data, ack_to_send, sda_in
//   result    empty / pop            scl_level, sda_level, busy_res, done_res,
//                                    read_data, ack_received
//   config    cfg_we                 cfg_wdata = half_period_ticks
//
// Every input word is one bus tick and yields exactly one result word, in order.
// The sequencer advances one tick per clock unless a side stalls, so the block
// then sustains one word per cycle; each word is registered in the input queue
// and then in the result queue. Either side may stall freely: the input queue and
// the result queue each hold QUEUE_DEPTH words. Reset (arst_n low) empties both
// queues, idles the bus with SCL and SDA high and sets the half period to five ticks.
module i2c_master_byte_engine #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd_valid,
	input  logic [2:0]  mode,
	input  logic [7:0]  write_data,
	input  logic        ack_to_send,
	input  logic        sda_in,
	output logic        empty,
	input  logic        pop,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_received,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import i2cm_pkg::*;

	logic [15:0] half_period_q;
	item_t       item;
	logic        item_valid, item_take;
	res_t        res, res_out;
	logic        res_push, out_full;

	// The user must rewrite the half period only while no word is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	i2cm_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd_valid  (cmd_valid),
		.mode       (mode),
		.write_data (write_data),
		.ack_to_send(ack_to_send),
		.sda_in     (sda_in),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	// The sequencer takes one queued tick per cycle whenever the result queue has room.
	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_period(half_period_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.out_full   (out_full),
		.res        (res),
		.res_push   (res_push)
	);

	i2cm_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign scl_level    = res_out.scl;
	assign sda_level    = res_out.sda;
	assign busy_res     = res_out.busy;
	assign done_res     = res_out.done;
	assign read_data    = res_out.read_data;
	assign ack_received = res_out.ack_received;

endmodule

@@ hdl/i2cm_checker.sv @@
// Port-level checks for the I2C master byte engine, bound onto the top level.
// Depends only on the top level's ports.
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        scl_level,
	input logic        sda_level,
	input logic        busy_res,
	input logic        done_res,
	input logic [7:0]  read_data,
	input logic        ack_received
);

	// A done word always belongs to a command in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && done_res |-> busy_res)
	else $error("done word without busy");

	// An accepted word reaches the result side once it has passed both queues.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> ##1 !empty)
	else $error("accepted word did not reach the result side");

	// A waiting word does not change while it is not popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(scl_level) && $stable(sda_level) &&
			$stable(read_data) && $stable(ack_received))
	else $error("stalled result word changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.scl_level   (scl_level),
	.sda_level   (sda_level),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.read_data   (read_data),
	.ack_received(ack_received)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the I2C master byte engine: bus ticks in, pin and status words out.
// Depends on i2cm_pkg and i2c_master_byte_engine; an in-bench predictor supplies the untyped words.
`timescale 1ns / 1ps

module tb_top;
	import i2cm_pkg::*;

	// Mode codes the block must ignore.
	localparam logic [2:0] MODE_RSVD_A = 3'd5;
	localparam logic [2:0] MODE_RSVD_B = 3'd6;
	localparam logic [2:0] MODE_RSVD_C = 3'd7;

	// The longest quiet stretch in a correct run is the deliberate result stall
	// (STALL_CYCLES) plus handshake slack, so the watchdog
	// allows several times that before it calls the run dead.
	localparam int STALL_CYCLES = 400;
	localparam int QUIET_LIMIT  = 2000;

	// One bus tick as it goes into the block.
	typedef struct packed {
		logic       cv;
		logic [2:0] md;
		logic [7:0] wd;
		logic       ak;
		logic       sd;
	} tick_t;

	// One row of the directed plan. A row with drain set keeps feeding filler
	// ticks (its own fields, with cv replaced by busy_cmds) until the command
	// it started has finished. A typed row carries its expected word directly.
	typedef struct packed {
		tick_t w;
		logic  drain;
		logic  busy_cmds;
		logic  typed;
		res_t  want;
	} row_t;

	// Pins released high, nothing in progress, registers at their reset values.
	localparam res_t BUS_IDLE = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
		read_data: 8'h00, ack_received: 1'b1};
	localparam res_t UNTYPED = '0;

	//                 cv    mode         data   ack   sda    drain busy  typed want
	localparam row_t PLAN [19] = '{
		// Before any command: plain idle ticks and unknown modes leave the bus alone.
		'{'{1'b0, MODE_START,  8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, 1'b1, BUS_IDLE},
		'{'{1'b1, MODE_RSVD_C, 8'hFF, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b1, BUS_IDLE},
		'{'{1'b1, MODE_RSVD_A, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, 1'b1, BUS_IDLE},
		'{'{1'b1, MODE_RSVD_B, 8'h5A, 1'b1, 1'b0}, 1'b0, 1'b0, 1'b1, BUS_IDLE},
		'{'{1'b0, MODE_WRITE,  8'hFF, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b1, BUS_IDLE},
		// Start with the same command offered on every busy tick, done tick included.
		'{'{1'b1, MODE_START,  8'h00, 1'b0, 1'b1}, 1'b1, 1'b1, 1'b0, UNTYPED},
		'{'{1'b1, MODE_WRITE,  8'hFF, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_WRITE,  8'h00, 1'b1, 1'b1}, 1'b1, 1'b1, 1'b0, UNTYPED},
		'{'{1'b1, MODE_ACK,    8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_READ,   8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_ACK,    8'hFF, 1'b1, 1'b0}, 1'b1, 1'b1, 1'b0, UNTYPED},
		'{'{1'b1, MODE_READ,   8'hFF, 1'b1, 1'b0}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_STOP,   8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b0, MODE_STOP,   8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, UNTYPED},
		// A stop with no start before it is still just a stop.
		'{'{1'b1, MODE_STOP,   8'h00, 1'b0, 1'b1}, 1'b1, 1'b1, 1'b0, UNTYPED},
		'{'{1'b1, MODE_START,  8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_WRITE,  8'hA5, 1'b0, 1'b0}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_READ,   8'h00, 1'b1, 1'b1}, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{'{1'b1, MODE_STOP,   8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, UNTYPED}
	};

	// Every input is at a known level from time zero.
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        push        = 1'b0;
	logic        cmd_valid   = 1'b0;
	logic [2:0]  mode        = MODE_START;
	logic [7:0]  write_data  = 8'h00;
	logic        ack_to_send = 1'b0;
	logic        sda_in      = 1'b1;
	logic        pop         = 1'b0;
	logic        cfg_we      = 1'b0;
	logic [15:0] cfg_wdata   = 16'h0000;

	logic        full, empty;
	logic        scl_level, sda_level, busy_res, done_res, ack_received;
	logic [7:0]  read_data;

	always #4 clk = ~clk;

	i2c_master_byte_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd_valid   (cmd_valid),
		.mode        (mode),
		.write_data  (write_data),
		.ack_to_send (ack_to_send),
		.sda_in      (sda_in),
		.empty       (empty),
		.pop         (pop),
		.scl_level   (scl_level),
		.sda_level   (sda_level),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data),
		.ack_received(ack_received),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Bus sequencer predictor. It mirrors the block's state and is stepped
	// once per accepted word, producing the word the block must return.
	// ------------------------------------------------------------------
	logic [15:0] half_ticks = HALF_PERIOD_RESET;
	phase_t      bus_phase  = PH_IDLE;
	logic [3:0]  bits_done  = 4'd0;
	logic [7:0]  shifter    = 8'h00;
	logic [15:0] hold_left  = 16'd0;
	logic        ack_bit    = 1'b0;
	logic        scl_q      = 1'b1;
	logic        sda_q      = 1'b1;
	logic [7:0]  byte_read  = 8'h00;
	logic        ack_seen   = 1'b1;

	res_t due_words [$];
	int   errors        = 0;
	int   ticks_sent    = 0;
	int   words_checked = 0;
	int   cmds_started [5] = '{default: 0};
	int   send_gap      = 12;
	int   recv_gap      = 46;
	int   holds_asked   = 0;
	int   holds_given   = 0;
	int   stall_left    = 0;
	int   quiet         = 0;

	// Entering a phase sets the pins at once and loads the hold counter.
	// A half period of zero behaves like one.
	function automatic void goto_phase(phase_t p, logic sda_now);
		logic [15:0] h;
		h = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
		bus_phase = p;
		hold_left = h - 16'd1;
		case (p)
			PH_S1: begin
				scl_q = 1'b1;
				sda_q = 1'b1;
			end
			PH_S2: sda_q = 1'b0;
			PH_WLOW: begin
				// The first bit goes out with SCL still where start left it.
				if (bits_done != 4'd0)
					scl_q = 1'b0;
				sda_q = shifter[7];
			end
			PH_ALOW: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
			end
			PH_AHIGH: begin
				scl_q    = 1'b1;
				ack_seen = sda_now;
			end
			PH_RLOW: begin
				if (bits_done != 4'd0)
					scl_q = 1'b0;
				sda_q = 1'b1;
			end
			PH_RHIGH: begin
				scl_q   = 1'b1;
				shifter = {shifter[6:0], sda_now};
			end
			PH_REND: begin
				scl_q     = 1'b0;
				byte_read = shifter;
			end
			PH_KLOW: sda_q = ack_bit;
			PH_T1: begin
				scl_q = 1'b0;
				sda_q = 1'b0;
			end
			PH_T3: sda_q = 1'b1;
			PH_WHIGH, PH_KHIGH, PH_T2: scl_q = 1'b1;
			PH_S3, PH_AEND, PH_KEND: scl_q = 1'b0;
			default: ;
		endcase
	endfunction

	function automatic phase_t after_phase(phase_t p);
		case (p)
			PH_WHIGH: begin
				bits_done = bits_done + 4'd1;
				shifter   = shifter << 1;
				return (bits_done >= 4'd8) ? PH_ALOW : PH_WLOW;
			end
			PH_RHIGH: begin
				bits_done = bits_done + 4'd1;
				return (bits_done >= 4'd8) ? PH_REND : PH_RLOW;
			end
			PH_S1, PH_S2, PH_WLOW, PH_ALOW, PH_AHIGH, PH_RLOW, PH_KLOW, PH_KHIGH,
			PH_T1, PH_T2:
				return phase_t'(p + 5'd1);
			default:
				return PH_IDLE;
		endcase
	endfunction

	function automatic res_t step_bus(tick_t w);
		res_t r;
		if (bus_phase == PH_IDLE) begin
			// Only a valid, known mode starts anything; busy ticks never do.
			if (w.cv && w.md <= MODE_STOP) begin
				bits_done = 4'd0;
				shifter   = (w.md == MODE_WRITE) ? w.wd : 8'h00;
				ack_bit   = w.ak;
				cmds_started[w.md]++;
				case (w.md)
					MODE_START: goto_phase(PH_S1, w.sd);
					MODE_WRITE: goto_phase(PH_WLOW, w.sd);
					MODE_READ:  goto_phase(PH_RLOW, w.sd);
					MODE_ACK:   goto_phase(PH_KLOW, w.sd);
					default:    goto_phase(PH_T1, w.sd);
				endcase
			end
		end else if (hold_left != 16'd0) begin
			hold_left = hold_left - 16'd1;
		end else begin
			goto_phase(after_phase(bus_phase), w.sd);
		end

		r = '0;
		if (bus_phase != PH_IDLE) begin
			r.busy = 1'b1;
			// The end phases finish on the tick they are entered; the final stop
			// phase finishes on the last tick of its hold.
			if (bus_phase == PH_S3 || bus_phase == PH_AEND || bus_phase == PH_REND ||
					bus_phase == PH_KEND || (bus_phase == PH_T3 && hold_left == 16'd0)) begin
				r.done    = 1'b1;
				bus_phase = PH_IDLE;
				hold_left = 16'd0;
			end
		end
		r.scl          = scl_q;
		r.sda          = sda_q;
		r.read_data    = byte_read;
		r.ack_received = ack_seen;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------
	function automatic tick_t random_tick();
		tick_t t;
		t.cv = 1'($urandom_range(1));
		t.md = 3'($urandom_range(7));
		t.wd = 8'($urandom_range(255));
		t.ak = 1'($urandom_range(1));
		t.sd = 1'($urandom_range(1));
		return t;
	endfunction

	// Offers one word and returns at the edge that takes it. Before offering,
	// the sender may drop push for idle cycles, each with the chance that the
	// current idling pattern gives.
	task automatic put_tick(tick_t w, logic typed, res_t want);
		while ($urandom_range(99) < send_gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		cmd_valid   <= w.cv;
		mode        <= w.md;
		write_data  <= w.wd;
		ack_to_send <= w.ak;
		sda_in      <= w.sd;
		@(posedge clk);
		while (full)
			@(posedge clk);
		// Typed rows still step the predictor so its state stays in line.
		if (typed) begin
			void'(step_bus(w));
			due_words.push_back(want);
		end else begin
			due_words.push_back(step_bus(w));
		end
		ticks_sent++;
	endtask

	// Keeps ticking until the command in progress has completed. In shuffled
	// mode the filler carries random SDA levels and now and then a command,
	// which the block must ignore while busy.
	task automatic ride_out(tick_t base, logic shuffle);
		tick_t f;
		while (bus_phase != PH_IDLE) begin
			f = base;
			if (shuffle) begin
				f    = random_tick();
				f.cv = ($urandom_range(7) == 0);
			end
			put_tick(f, 1'b0, UNTYPED);
		end
	endtask

	task automatic launch(logic [2:0] md);
		tick_t t;
		t    = random_tick();
		t.cv = 1'b1;
		t.md = md;
		put_tick(t, 1'b0, UNTYPED);
		ride_out(t, 1'b1);
	endtask

	// Mostly complete transfers (start, a few bytes, stop) with random data and
	// slave responses; the rest is stray ticks and transfers missing a start or an end.
	task automatic random_traffic(int budget);
		int    stop_at;
		int    n;
		tick_t t;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(99) < 10) begin
				t = random_tick();
				put_tick(t, 1'b0, UNTYPED);
				ride_out(t, 1'b1);
			end else begin
				if ($urandom_range(9) != 0)
					launch(MODE_START);
				n = $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(1) != 0) begin
						launch(MODE_WRITE);
					end else begin
						launch(MODE_READ);
						launch(MODE_ACK);
					end
				end
				if ($urandom_range(9) != 0)
					launch(MODE_STOP);
			end
			if ($urandom_range(3) == 0) begin
				t    = random_tick();
				t.cv = 1'b0;
				put_tick(t, 1'b0, UNTYPED);
			end
		end
	endtask

	// Stops offering and waits until every expected word has come back.
	task automatic drain();
		push <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written with the bus idle and both queues empty,
	// plus a wait for the block's queue registers to settle.
	task automatic set_half_period(logic [15:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		half_ticks  = v;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: checks each word taken and decides pop for the next edge.
	// ------------------------------------------------------------------
	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic check_word();
		res_t want;
		if (due_words.size() == 0) begin
			$error("result word arrived with nothing expected");
			errors++;
		end else begin
			want = due_words.pop_front();
			compare_field("scl_level", 8'(want.scl), 8'(scl_level));
			compare_field("sda_level", 8'(want.sda), 8'(sda_level));
			compare_field("busy_res", 8'(want.busy), 8'(busy_res));
			compare_field("done_res", 8'(want.done), 8'(done_res));
			compare_field("read_data", want.read_data, read_data);
			compare_field("ack_received", 8'(want.ack_received), 8'(ack_received));
			words_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_word();
			if (stall_left != 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (holds_given != holds_asked) begin
				// Long hold-off: the sender keeps pushing until the block fills up.
				holds_given++;
				stall_left = STALL_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_gap);
			end
		end
	end

	// Watchdog on progress: any word moving on either side resets it.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: no word moved for %0d cycles", QUIET_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		tick_t base;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan at the reset half period, sender idling lightly and
		// the receiver heavily.
		foreach (PLAN[i]) begin
			put_tick(PLAN[i].w, PLAN[i].typed, PLAN[i].want);
			if (PLAN[i].drain) begin
				base    = PLAN[i].w;
				base.cv = PLAN[i].busy_cmds;
				ride_out(base, 1'b0);
			end
		end

		set_half_period(16'd1);
		random_traffic(200);

		// Zero half period, with a long result stall early on.
		set_half_period(16'd0);
		holds_asked++;
		random_traffic(150);

		// Swap the idling pattern: the sender now idles heavily.
		send_gap = 46;
		recv_gap = 12;
		set_half_period(16'd2);
		random_traffic(100);
		// Sender pause until everything outstanding has returned.
		drain();
		random_traffic(50);
		set_half_period(16'd3);
		random_traffic(150);

		// Neither side idles from here on.
		send_gap = 0;
		recv_gap = 0;
		set_half_period(16'd1);
		random_traffic(150);

		// Largest half period: the register takes its top value and the idle
		// bus keeps its levels.
		set_half_period(16'hFFFF);
		base    = random_tick();
		base.cv = 1'b0;
		repeat (4) put_tick(base, 1'b0, UNTYPED);

		drain();
		repeat (8) @(posedge clk);

		$display("tb_top: %0d ticks driven, %0d words checked, half periods 5 1 0 2 3 1 65535",
			ticks_sent, words_checked);
		$display("tb_top: commands started (start/write/read/ack/stop) %0d/%0d/%0d/%0d/%0d",
			cmds_started[MODE_START], cmds_started[MODE_WRITE], cmds_started[MODE_READ],
			cmds_started[MODE_ACK], cmds_started[MODE_STOP]);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ i2c_master_byte_engine.f @@
hdl/i2cm_pkg.sv
hdl/i2cm_fifo.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_byte_engine.sv
hdl/i2cm_checker.sv
tb/sv/tb_top.sv
